@@ sv/vnf_pkg.sv @@
`default_nettype none
package vnf_pkg;
	// control travelling alongside each word in the pipeline
	typedef struct packed {
		logic valid;
		logic zero;
	} vnf_ctl_t;
endpackage
`default_nettype wire

@@ sv/vnf_sqrt_cell.sv @@
`default_nettype none
// One restoring square-root step: settle one root bit per cycle
module vnf_sqrt_cell import vnf_pkg::*; #(
	parameter int SW = 66,
	parameter int RW = 33,
	parameter int MW = 32,
	parameter int BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vnf_ctl_t      ctl_i,
	input  wire logic [SW-1:0] rem_i,
	input  wire logic [RW-1:0] root_i,
	input  wire logic [MW-1:0] mx_i,
	input  wire logic [MW-1:0] my_i,
	input  wire logic [MW-1:0] mz_i,
	input  wire logic [2:0]    neg_i,
	output vnf_ctl_t           ctl_o,
	output logic [SW-1:0]      rem_o,
	output logic [RW-1:0]      root_o,
	output logic [MW-1:0]      mx_o,
	output logic [MW-1:0]      my_o,
	output logic [MW-1:0]      mz_o,
	output logic [2:0]         neg_o
);
	logic [SW+1:0] trial;
	logic          fits;

	// trial = (2*root + 2^BIT) << BIT, compared against the remainder
	always_comb begin
		trial = ({{(SW+1-RW){1'b0}}, root_i, 1'b0} | ((SW+2)'(1) << BIT)) << BIT;
		fits  = ({2'b00, rem_i} >= trial);
	end

	// advance the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_o  <= fits ? SW'({2'b00, rem_i} - trial) : rem_i;
		root_o <= fits ? (root_i | (RW'(1) << BIT)) : root_i;
		mx_o   <= mx_i;
		my_o   <= my_i;
		mz_o   <= mz_i;
		neg_o  <= neg_i;
	end
endmodule
`default_nettype wire

@@ sv/vnf_div_cell.sv @@
`default_nettype none
// One restoring division step for all three lanes: one quotient bit per cycle
module vnf_div_cell import vnf_pkg::*; #(
	parameter int NW = 62,
	parameter int RW = 33,
	parameter int QW = 32,
	parameter int BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vnf_ctl_t      ctl_i,
	input  wire logic [RW-1:0] den_i,
	input  wire logic [NW-1:0] num_i [3],
	input  wire logic [RW:0]   rem_i [3],
	input  wire logic [QW-1:0] quo_i [3],
	input  wire logic [2:0]    neg_i,
	output vnf_ctl_t           ctl_o,
	output logic [RW-1:0]      den_o,
	output logic [NW-1:0]      num_o [3],
	output logic [RW:0]        rem_o [3],
	output logic [QW-1:0]      quo_o [3],
	output logic [2:0]         neg_o
);
	logic [RW+1:0] shifted [3];
	logic [2:0]    fits;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			shifted[k] = {rem_i[k], num_i[k][BIT]};
			fits[k]    = (shifted[k] >= {2'b00, den_i});
		end
	end

	// advance the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		den_o <= den_i;
		neg_o <= neg_i;
		for (int k = 0; k < 3; k++) begin
			num_o[k] <= num_i[k];
			rem_o[k] <= fits[k] ? (RW+1)'(shifted[k] - {2'b00, den_i})
			                    : (RW+1)'(shifted[k]);
			quo_o[k] <= fits[k] ? (quo_i[k] | (QW'(1) << (BIT % QW))) : quo_i[k];
		end
	end
endmodule
`default_nettype wire

@@ sv/vec3_normalize_fixed.sv @@
`default_nettype none
// Pipeline: a magnitude stage, a square-and-sum stage, one root-bit cell per
// root bit, one quotient-bit cell per numerator bit, then the output
// register.
// Throughput: one vector per cycle; busy is held low.
// Reset: arst_n clears all word-valid flags; data registers are not reset.
// Results cannot be stalled: each shows for one cycle with done high.
module vec3_normalize_fixed import vnf_pkg::*; #(
	parameter int COMPONENT_BITS = 32,
	parameter int OUT_FRACTION_BITS = 30
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic signed [COMPONENT_BITS-1:0] in_x,
	input  wire logic signed [COMPONENT_BITS-1:0] in_y,
	input  wire logic signed [COMPONENT_BITS-1:0] in_z,
	output logic                                  done,
	output logic signed [OUT_FRACTION_BITS+1:0]   out_x,
	output logic signed [OUT_FRACTION_BITS+1:0]   out_y,
	output logic signed [OUT_FRACTION_BITS+1:0]   out_z,
	output logic                                  is_zero
);
	localparam int MW = COMPONENT_BITS;
	localparam int SW = 2*MW + 2;
	localparam int RW = MW + 1;
	localparam int NW = MW + OUT_FRACTION_BITS;
	localparam int OW = OUT_FRACTION_BITS + 2;
	localparam int QW = OW;

	assign busy = 1'b0;

	// stage 1: magnitudes and signs
	vnf_ctl_t      ctl_s1;
	logic [MW-1:0] mag_s1 [3];
	logic [2:0]    neg_s1;
	logic [MW-1:0] raw [3];

	always_comb begin
		raw[0] = in_x;
		raw[1] = in_y;
		raw[2] = in_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= '{valid: start, zero: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			neg_s1[k] <= raw[k][MW-1];
			mag_s1[k] <= raw[k][MW-1] ? MW'(-raw[k]) : raw[k];
		end
	end

	// stage 2: squares and sum
	vnf_ctl_t      ctl_s2;
	logic [SW-1:0] sum_s2;
	logic [MW-1:0] mag_s2 [3];
	logic [2:0]    neg_s2;
	logic [SW-1:0] sq [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sq[k] = SW'(mag_s1[k]) * SW'(mag_s1[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sq[0] + sq[1] + sq[2];
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
	end

	// square-root chain, most significant root bit first
	vnf_ctl_t      s_ctl  [RW+1];
	logic [SW-1:0] s_rem  [RW+1];
	logic [RW-1:0] s_root [RW+1];
	logic [MW-1:0] s_mx   [RW+1];
	logic [MW-1:0] s_my   [RW+1];
	logic [MW-1:0] s_mz   [RW+1];
	logic [2:0]    s_neg  [RW+1];

	always_comb begin
		s_ctl[0]  = '{valid: ctl_s2.valid, zero: (sum_s2 == '0)};
		s_rem[0]  = sum_s2;
		s_root[0] = '0;
		s_mx[0]   = mag_s2[0];
		s_my[0]   = mag_s2[1];
		s_mz[0]   = mag_s2[2];
		s_neg[0]  = neg_s2;
	end

	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		vnf_sqrt_cell #(.SW(SW), .RW(RW), .MW(MW), .BIT(RW-1-i)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_i(s_ctl[i]), .rem_i(s_rem[i]), .root_i(s_root[i]),
			.mx_i(s_mx[i]), .my_i(s_my[i]), .mz_i(s_mz[i]), .neg_i(s_neg[i]),
			.ctl_o(s_ctl[i+1]), .rem_o(s_rem[i+1]), .root_o(s_root[i+1]),
			.mx_o(s_mx[i+1]), .my_o(s_my[i+1]), .mz_o(s_mz[i+1]), .neg_o(s_neg[i+1])
		);
	end

	// division chain, one numerator bit per cell
	vnf_ctl_t      d_ctl [NW+1];
	logic [RW-1:0] d_den [NW+1];
	logic [NW-1:0] d_num [NW+1][3];
	logic [RW:0]   d_rem [NW+1][3];
	logic [QW-1:0] d_quo [NW+1][3];
	logic [2:0]    d_neg [NW+1];

	always_comb begin
		d_ctl[0]    = s_ctl[RW];
		d_den[0]    = s_root[RW];
		d_num[0][0] = {s_mx[RW], {OUT_FRACTION_BITS{1'b0}}};
		d_num[0][1] = {s_my[RW], {OUT_FRACTION_BITS{1'b0}}};
		d_num[0][2] = {s_mz[RW], {OUT_FRACTION_BITS{1'b0}}};
		d_neg[0]    = s_neg[RW];
		for (int k = 0; k < 3; k++) begin
			d_rem[0][k] = '0;
			d_quo[0][k] = '0;
		end
	end

	for (genvar i = 0; i < NW; i++) begin : g_div
		vnf_div_cell #(.NW(NW), .RW(RW), .QW(QW), .BIT(NW-1-i)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_i(d_ctl[i]), .den_i(d_den[i]), .num_i(d_num[i]),
			.rem_i(d_rem[i]), .quo_i(d_quo[i]), .neg_i(d_neg[i]),
			.ctl_o(d_ctl[i+1]), .den_o(d_den[i+1]), .num_o(d_num[i+1]),
			.rem_o(d_rem[i+1]), .quo_o(d_quo[i+1]), .neg_o(d_neg[i+1])
		);
	end

	// output register: apply signs, force zero word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= d_ctl[NW].valid;
		end
	end

	always_ff @(posedge clk) begin
		is_zero <= d_ctl[NW].zero;
		if (d_ctl[NW].zero) begin
			out_x <= '0;
			out_y <= '0;
			out_z <= '0;
		end else begin
			out_x <= d_neg[NW][0] ? OW'(-d_quo[NW][0]) : d_quo[NW][0];
			out_y <= d_neg[NW][1] ? OW'(-d_quo[NW][1]) : d_quo[NW][1];
			out_z <= d_neg[NW][2] ? OW'(-d_quo[NW][2]) : d_quo[NW][2];
		end
	end
endmodule
`default_nettype wire

@@ tb/vec3_normalize_checker.sv @@
`default_nettype none
module vec3_normalize_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic signed [31:0] in_x,
	input  wire logic signed [31:0] in_y,
	input  wire logic signed [31:0] in_z,
	input  wire logic               done,
	input  wire logic signed [31:0] out_x,
	input  wire logic signed [31:0] out_y,
	input  wire logic signed [31:0] out_z,
	input  wire logic               is_zero,
	output int                      fail_count,
	output int                      pending
);
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        zero;
	} unit_vec_t;

	unit_vec_t unit_q[$];

	assign pending = unit_q.size();

	// floor of the square root of a 66-bit sum of squares
	function automatic logic [63:0] length_floor(input logic [65:0] sum);
		logic [63:0] root;
		logic [63:0] cand;
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= {62'd0, sum})
				root = cand;
		end
		return root;
	endfunction

	// one normalised component, truncated toward zero
	function automatic logic [31:0] scale_comp(input logic signed [31:0] c,
			input logic [63:0] len);
		logic [32:0] mag;
		logic [95:0] num;
		logic [95:0] quo;
		mag = c[31] ? (33'd0 - {c[31], c}) : {1'b0, c};
		num = {63'd0, mag} << 30;
		quo = num / {32'd0, len};
		return c[31] ? (32'd0 - quo[31:0]) : quo[31:0];
	endfunction

	function automatic unit_vec_t predict_unit(input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		logic signed [65:0] sum;
		logic [63:0] len;
		unit_vec_t r;
		sum = 66'(x) * 66'(x) + 66'(y) * 66'(y) + 66'(z) * 66'(z);
		if (sum == 0) begin
			r = '{x: '0, y: '0, z: '0, zero: 1'b1};
		end else begin
			len = length_floor(sum);
			r = '{x: scale_comp(x, len), y: scale_comp(y, len),
				z: scale_comp(z, len), zero: 1'b0};
		end
		return r;
	endfunction

	// predict on accepted words, compare on each strobed result
	always @(posedge clk or negedge arst_n) begin
		unit_vec_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy)
				unit_q.push_back(predict_unit(in_x, in_y, in_z));
			if (done) begin
				if (unit_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h %h %h z=%b",
							out_x, out_y, out_z, is_zero);
					fail_count <= fail_count + 1;
				end else begin
					want = unit_q.pop_front();
					if (want.x !== out_x || want.y !== out_y || want.z !== out_z ||
							want.zero !== is_zero) begin
						if (fail_count < 10)
							$display("mismatch: want %h %h %h z=%b got %h %h %h z=%b",
								want.x, want.y, want.z, want.zero,
								out_x, out_y, out_z, is_zero);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ tb/vec3_normalize_fixed_tb.sv @@
`default_nettype none
module vec3_normalize_fixed_tb;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] in_x = '0;
	logic signed [31:0] in_y = '0;
	logic signed [31:0] in_z = '0;
	logic               done;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic               is_zero;
	int                 fail_count;
	int                 pending;

	localparam logic [31:0] MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] MOST_POS = 32'h7fff_ffff;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	vec3_normalize_fixed dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_x(in_x), .in_y(in_y), .in_z(in_z),
		.done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.is_zero(is_zero)
	);

	vec3_normalize_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_x(in_x), .in_y(in_y), .in_z(in_z),
		.done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.is_zero(is_zero), .fail_count(fail_count), .pending(pending)
	);

	// random component: full range, small magnitudes or extremes
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom_range(0, 15))
				- 32'd8;
			1: return $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
			2: return 32'($urandom_range(0, 2000)) - 32'd1000;
			default: return $urandom();
		endcase
	endfunction

	// present one word and hold until accepted, then idle a random gap
	task automatic send_vec(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input bit idle_ok);
		int gap;
		start <= 1'b1;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		gap = 0;
		if (idle_ok && $urandom_range(0, 2) == 0)
			gap = $urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	initial begin
		logic [31:0] dir[$];
		int wait_cycles;
		dir = '{32'd0, 32'd1, 32'hffff_ffff, MOST_NEG, MOST_POS, 32'h0001_0000,
			32'h5555_5555, 32'haaaa_aaaa};
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero vector, axis vectors, extremes, short vectors
		send_vec(0, 0, 0, 0);
		send_vec(1, 0, 0, 0);
		send_vec(0, 32'hffff_ffff, 0, 1);
		send_vec(0, 0, MOST_NEG, 0);
		send_vec(MOST_NEG, MOST_NEG, MOST_NEG, 0);
		send_vec(MOST_POS, MOST_POS, MOST_POS, 1);
		send_vec(MOST_NEG, MOST_POS, 0, 0);
		send_vec(1, 1, 1, 0);
		send_vec(32'hffff_ffff, 1, 32'hffff_ffff, 0);
		send_vec(3, 4, 0, 1);
		send_vec(32'h0001_0000, 32'h0001_0000, 0, 0);
		send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h7fff_0000, 0);
		send_vec(32'haaaa_aaaa, 32'h5555_5555, 32'h0000_ffff, 1);
		for (int i = 0; i < 8; i++)
			send_vec(dir[$urandom_range(0, 7)], dir[$urandom_range(0, 7)],
				dir[$urandom_range(0, 7)], $urandom_range(0, 1));
		// random part, with stretches free of gaps
		for (int i = 0; i < 1250; i++)
			send_vec(rand_comp(), rand_comp(), rand_comp(), (i / 100) % 3 != 1);
		start <= 1'b0;
		// drain, then allow the pipeline latency
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (120)
			@(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hard stop
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
